// ===== rtl/core/skhs_pkg.sv =====
// shared constants and types for the sorted key halving search block
`timescale 1ns / 1ps

package skhs_pkg;

   // table geometry and field widths
   localparam int unsigned DEPTH  = 1024;
   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = ADDR_W + 1;
   localparam int unsigned KEY_W  = 32;

   // request operation codes
   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   // search sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_NBR,
      ST_NCMP,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/skhs_if.sv =====
// request, response and register write channel interfaces
`timescale 1ns / 1ps

interface skhs_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [skhs_pkg::ADDR_W-1:0]    slot;
   logic [skhs_pkg::KEY_W-1:0]     key;

   modport source (output valid, output op, output slot, output key, input ready);
   modport sink   (input valid, input op, input slot, input key, output ready);
endinterface

interface skhs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic [skhs_pkg::CNT_W-1:0]     position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

interface skhs_csr_if;
   logic                           valid;
   logic                           ready;
   logic [skhs_pkg::CNT_W-1:0]     data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/skhs_ram.sv =====
// generic single write port ram with a registered read port
`timescale 1ns / 1ps

module skhs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/sorted_key_halving_search.sv =====
// top level of the sorted key halving search block
//
// Holds a table of 32-bit ids, kept sorted ascending by software, in a
// single-port-read ram. Requests arrive on req_if: op write stores key at
// slot and gives no response; op search looks for key and gives one
// response on rsp_if with found and position (matching index, or the
// entry count on a miss). The entry count is written through csr_if;
// the user must write it only while the block is idle, which the block
// itself does not enforce; counts above the table depth saturate. A
// write request is done on accept. A search walks the table from index
// 0 with a halving step; each probe is one ram read and one compare, and
// the unit-step probe adds a neighbour read and compare. A hit ends the
// search early, and each further unit-step move repeats the probe and
// the neighbour read. An empty table skips the walk and answers with a
// miss. The block takes one request at a time. A finished response sits
// in an output register; if the receiver stalls, the next search waits
// for that register before completing. Reset clears the entry count, the
// sequencer and the response valid; the table holds nothing meaningful
// until written.
`timescale 1ns / 1ps

module sorted_key_halving_search (
   input logic       clock,
   input logic       reset,
   skhs_req_if.sink  req_if,
   skhs_rsp_if.source rsp_if,
   skhs_csr_if.sink  csr_if
);

   localparam int unsigned AW = skhs_pkg::ADDR_W;
   localparam int unsigned CW = skhs_pkg::CNT_W;
   localparam int unsigned KW = skhs_pkg::KEY_W;

   skhs_pkg::state_type state_ff, state_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] n_ff, n_in;
   logic [KW-1:0] key_ff, key_in;
   logic          up_ff, up_in;
   logic          res_found_ff, res_found_in;
   logic [CW-1:0] res_pos_ff, res_pos_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          found_ff, found_in;
   logic [CW-1:0] position_ff, position_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   logic          ram_we;
   logic [AW-1:0] ram_raddr;
   logic [KW-1:0] ram_rdata;

   logic          req_fire;
   logic [CW-1:0] cnt_sat;
   logic [CW-1:0] step_half;
   logic [CW-1:0] step_nx;
   logic [CW-1:0] pos_ext;
   logic [CW-1:0] room;
   logic [CW-1:0] n_m1;
   logic          out_free;

   // table storage
   skhs_ram #(
      .WIDTH (KW),
      .DEPTH (skhs_pkg::DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_if.slot),
      .wdata (req_if.key),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // handshakes
   assign req_if.ready = (state_ff == skhs_pkg::ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign ram_we       = req_fire && (req_if.op == skhs_pkg::OP_WRITE);
   assign csr_if.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.found    = found_ff;
   assign rsp_if.position = position_ff;

   // saturated count and step arithmetic
   assign cnt_sat   = (cnt_ff > CW'(skhs_pkg::DEPTH)) ? CW'(skhs_pkg::DEPTH) : cnt_ff;
   assign step_half = step_ff >> 1;
   assign step_nx   = (step_half == '0) ? CW'(1) : step_half;
   assign pos_ext   = {1'b0, pos_ff};
   assign room      = n_ff - pos_ext;
   assign n_m1      = n_ff - CW'(1);

   // entry count register
   always_comb begin
      cnt_in = cnt_ff;
      if (csr_if.valid && csr_if.ready) begin
         cnt_in = csr_if.data;
      end
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skhs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      step_ff      <= step_in;
      n_ff         <= n_in;
      key_ff       <= key_in;
      up_ff        <= up_in;
      res_found_ff <= res_found_in;
      res_pos_ff   <= res_pos_in;
      found_ff     <= found_in;
      position_ff  <= position_in;
   end

   // search sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      step_in      = step_ff;
      n_in         = n_ff;
      key_in       = key_ff;
      up_in        = up_ff;
      res_found_in = res_found_ff;
      res_pos_in   = res_pos_ff;
      found_in     = found_ff;
      position_in  = position_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      ram_raddr    = pos_ff;

      unique case (state_ff)
         skhs_pkg::ST_IDLE: begin
            if (req_fire && (req_if.op == skhs_pkg::OP_SEARCH)) begin
               key_in  = req_if.key;
               n_in    = cnt_sat;
               step_in = cnt_sat;
               pos_in  = '0;
               if (cnt_sat == '0) begin
                  res_found_in = 1'b0;
                  res_pos_in   = '0;
                  state_in     = skhs_pkg::ST_DONE;
               end else begin
                  state_in = skhs_pkg::ST_PROBE;
               end
            end
         end

         skhs_pkg::ST_PROBE: begin
            // read the probed entry
            state_in = skhs_pkg::ST_CMP;
         end

         skhs_pkg::ST_CMP: begin
            step_in = step_nx;
            if (key_ff == ram_rdata) begin
               res_found_in = 1'b1;
               res_pos_in   = pos_ext;
               state_in     = skhs_pkg::ST_DONE;
            end else if (step_nx == CW'(1)) begin
               // unit step: check the neighbour before moving
               if (key_ff < ram_rdata) begin
                  up_in = 1'b0;
                  if (pos_ff == '0) begin
                     res_found_in = 1'b0;
                     res_pos_in   = n_ff;
                     state_in     = skhs_pkg::ST_DONE;
                  end else begin
                     state_in = skhs_pkg::ST_NBR;
                  end
               end else begin
                  up_in = 1'b1;
                  if (pos_ext == n_m1) begin
                     res_found_in = 1'b0;
                     res_pos_in   = n_ff;
                     state_in     = skhs_pkg::ST_DONE;
                  end else begin
                     state_in = skhs_pkg::ST_NBR;
                  end
               end
            end else begin
               // larger step: move with clamping at both ends
               if (key_ff < ram_rdata) begin
                  if (step_nx > pos_ext) begin
                     pos_in = '0;
                  end else begin
                     pos_in = AW'(pos_ext - step_nx);
                  end
               end else begin
                  if (step_nx >= room) begin
                     pos_in = AW'(n_m1);
                  end else begin
                     pos_in = AW'(pos_ext + step_nx);
                  end
               end
               state_in = skhs_pkg::ST_PROBE;
            end
         end

         skhs_pkg::ST_NBR: begin
            // read the neighbour in the direction of travel
            ram_raddr = up_ff ? AW'(pos_ff + AW'(1)) : AW'(pos_ff - AW'(1));
            state_in  = skhs_pkg::ST_NCMP;
         end

         skhs_pkg::ST_NCMP: begin
            if (up_ff) begin
               if (key_ff < ram_rdata) begin
                  res_found_in = 1'b0;
                  res_pos_in   = n_ff;
                  state_in     = skhs_pkg::ST_DONE;
               end else begin
                  pos_in   = AW'(pos_ff + AW'(1));
                  state_in = skhs_pkg::ST_PROBE;
               end
            end else begin
               if (key_ff > ram_rdata) begin
                  res_found_in = 1'b0;
                  res_pos_in   = n_ff;
                  state_in     = skhs_pkg::ST_DONE;
               end else begin
                  pos_in   = AW'(pos_ff - AW'(1));
                  state_in = skhs_pkg::ST_PROBE;
               end
            end
         end

         skhs_pkg::ST_DONE: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               found_in     = res_found_ff;
               position_in  = res_pos_ff;
               state_in     = skhs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = skhs_pkg::ST_IDLE;
         end
      endcase
   end

   // probe index stays inside the live table
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skhs_pkg::ST_PROBE) |-> (pos_ext < n_ff))
      else $error("probe index beyond entry count");

   // step never reaches zero while searching
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skhs_pkg::ST_CMP) |-> (step_ff != '0))
      else $error("search step is zero");

   // a pending miss always reports the entry count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skhs_pkg::ST_DONE && !res_found_ff) |-> (res_pos_ff == n_ff))
      else $error("miss position differs from entry count");

   // a finished search reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == skhs_pkg::ST_DONE && out_free) |=> (rsp_valid_ff && found_ff ==
      $past(res_found_ff) && position_ff == $past(res_pos_ff)))
      else $error("result not loaded into output register");

endmodule
